// File: sv/vdh_pkg.sv
// Shared types and constants for the voxel decay histogram core.
// Depends on nothing; the front end, back end and top import it.
package vdh_pkg;

  localparam int ID_W      = 32;
  localparam int CRYSTAL_W = 16;
  localparam int POS_W     = 24;
  localparam int RADDR_W   = 17;
  localparam int ADDR_W    = 20;   // largest event address with 7/7/6-bit grid registers
  localparam int OUT_W     = 32;
  localparam int GXY_W     = 7;
  localparam int GZ_W      = 6;
  localparam int SPLIT_W   = 16;
  localparam int PART_W    = 14;   // x + y*gx, also gx*gy
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_GRID_X      = 2'd0;
  localparam reg_idx_t REG_GRID_Y      = 2'd1;
  localparam reg_idx_t REG_GRID_Z      = 2'd2;
  localparam reg_idx_t REG_SPLIT_INDEX = 2'd3;

  localparam logic [GXY_W-1:0]   GRID_X_RST = 7'd64;
  localparam logic [GXY_W-1:0]   GRID_Y_RST = 7'd64;
  localparam logic [GZ_W-1:0]    GRID_Z_RST = 6'd32;
  localparam logic [SPLIT_W-1:0] SPLIT_RST  = 16'd32448;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [GXY_W-1:0]   grid_x;
    logic [GXY_W-1:0]   grid_y;
    logic [GZ_W-1:0]    grid_z;
    logic [SPLIT_W-1:0] split_index;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_LOW_LOW,
    CLS_HIGH_HIGH,
    CLS_MIXED
  } cls_t;

  typedef struct packed {
    logic              is_read;
    logic              is_true;
    cls_t              cls;
    logic              in_box;   // all three axes in the grid
    logic [ADDR_W-1:0] addr;
  } op_t;

  typedef struct packed {
    logic [OUT_W-1:0] voxel_count;
    logic             in_grid;
    logic [OUT_W-1:0] true_total;
    logic [OUT_W-1:0] count_low_low;
    logic [OUT_W-1:0] count_high_high;
    logic [OUT_W-1:0] count_mixed;
  } res_t;

endpackage

// File: sv/vdh_fifo.sv
// Small register queue, first word through on dout while not empty.
// Depends on nothing.
module vdh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign dout  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/vdh_front.sv
// Front end: accepts words, classifies them and works out the store address.
// Two-stage pipeline; depends on vdh_pkg.
module vdh_front #(
  parameter int DIM_X = 64,
  parameter int DIM_Y = 64,
  parameter int DIM_Z = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vdh_pkg::cfg_t                      cfg,
  input  logic                               hold,
  input  logic                               push,
  output logic                               full,
  input  logic                               kind,
  input  logic signed [vdh_pkg::ID_W-1:0]    coinc_id,
  input  logic [vdh_pkg::CRYSTAL_W-1:0]      crystal_a,
  input  logic [vdh_pkg::CRYSTAL_W-1:0]      crystal_b,
  input  logic signed [vdh_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vdh_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vdh_pkg::POS_W-1:0]   pos_z,
  input  logic [vdh_pkg::RADDR_W-1:0]        read_address,
  output logic                               op_valid,
  output vdh_pkg::op_t                       op,
  input  logic                               op_ready
);

  import vdh_pkg::*;

  function automatic logic [GXY_W-1:0] clamp_grid(input logic [GXY_W-1:0] g, input int dim);
    logic [GXY_W-1:0] r;
    if (g == '0) begin
      r = GXY_W'(1);
    end else if (32'(g) > dim) begin
      r = GXY_W'(dim);
    end else begin
      r = g;
    end
    return r;
  endfunction

  // {in grid, voxel}: floor of the signed 16.8 fixed point value, offset by g/2
  function automatic logic [GXY_W:0] axis_cell(input logic [POS_W-1:0] pos,
                                               input logic [GXY_W-1:0] g);
    logic [17:0] c;
    c = {{2{pos[23]}}, pos[23:8]} + {12'd0, g[GXY_W-1:1]};
    return {(~c[17]) && (c[16:0] < {10'd0, g}), c[GXY_W-1:0]};
  endfunction

  logic [GXY_W-1:0]  gx;
  logic [GXY_W-1:0]  gy;
  logic [GXY_W-1:0]  gz;
  logic [GXY_W:0]    ax;
  logic [GXY_W:0]    ay;
  logic [GXY_W:0]    az;
  logic [PART_W-1:0] part_c;
  cls_t              cls_c;
  logic              a_low;
  logic              b_low;

  logic [PART_W-1:0]  gxy;
  logic               s1_valid;
  logic               s1_read;
  logic               s1_true;
  cls_t               s1_cls;
  logic               s1_inside;
  logic [RADDR_W-1:0] s1_raddr;
  logic [PART_W-1:0]  s1_part;
  logic [GZ_W-1:0]    s1_z;

  logic              s1_ready;
  logic              s2_ready;
  logic              accept;
  logic [ADDR_W-1:0] z_term;
  op_t               op_next;

  assign gx = clamp_grid(cfg.grid_x, DIM_X);
  assign gy = clamp_grid(cfg.grid_y, DIM_Y);
  assign gz = clamp_grid({1'b0, cfg.grid_z}, DIM_Z);

  assign ax = axis_cell(pos_x, gx);
  assign ay = axis_cell(pos_y, gy);
  assign az = axis_cell(pos_z, gz);

  assign part_c = PART_W'({7'd0, ay[GXY_W-1:0]} * {7'd0, gx}) + PART_W'(ax[GXY_W-1:0]);

  assign a_low = crystal_a < cfg.split_index;
  assign b_low = crystal_b < cfg.split_index;

  always_comb begin
    if (a_low && b_low) begin
      cls_c = CLS_LOW_LOW;
    end else if (!a_low && !b_low) begin
      cls_c = CLS_HIGH_HIGH;
    end else begin
      cls_c = CLS_MIXED;
    end
  end

  assign s2_ready = !op_valid || op_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready || hold;
  assign accept   = push && !full;

  assign z_term = ADDR_W'({14'd0, s1_z} * {6'd0, gxy});

  always_comb begin
    op_next.is_read = s1_read;
    op_next.is_true = s1_true;
    op_next.cls     = s1_cls;
    op_next.in_box  = s1_inside;
    op_next.addr    = s1_read ? ADDR_W'(s1_raddr) : ADDR_W'(s1_part) + z_term;
  end

  // the user must change the grid registers only while the block is idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    gxy <= PART_W'({7'd0, gx} * {7'd0, gy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      op_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= accept;
      end
      if (s2_ready) begin
        op_valid <= s1_valid;
      end
    end
    if (accept) begin
      s1_read   <= (kind == KIND_READ);
      s1_true   <= !coinc_id[ID_W-1];
      s1_cls    <= cls_c;
      s1_inside <= ax[GXY_W] && ay[GXY_W] && az[GXY_W];
      s1_raddr  <= read_address;
      s1_part   <= part_c;
      s1_z      <= az[GZ_W-1:0];
    end
    if (s1_valid && s2_ready) begin
      op <= op_next;
    end
  end

endmodule

// File: sv/vdh_back.sv
// Back end: count store read-modify-write, class counters, clear pass.
// Depends on vdh_pkg.
module vdh_back #(
  parameter int DIM_X      = 64,
  parameter int DIM_Y      = 64,
  parameter int DIM_Z      = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  vdh_pkg::op_t  op_in,
  input  logic          op_empty,
  output logic          op_pop,
  output vdh_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full,
  output logic          clearing
);

  import vdh_pkg::*;

  localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  state_t                state;
  logic [AW-1:0]         clr_addr;
  op_t                   op;
  logic [COUNT_BITS-1:0] cnt_true;
  logic [COUNT_BITS-1:0] cnt_ll;
  logic [COUNT_BITS-1:0] cnt_hh;
  logic [COUNT_BITS-1:0] cnt_mx;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;

  logic [AW-1:0]         idx;
  logic                  hit;
  logic                  ev;
  logic                  upd;
  logic [COUNT_BITS-1:0] vox_inc;
  logic [COUNT_BITS-1:0] true_next;
  logic [COUNT_BITS-1:0] ll_next;
  logic [COUNT_BITS-1:0] hh_next;
  logic [COUNT_BITS-1:0] mx_next;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  assign idx     = AW'(op.addr);
  assign hit     = {12'd0, op.addr} < 32'(DEPTH);
  assign ev      = !op.is_read && op.is_true;
  assign upd     = ev && op.in_box && hit;
  assign vox_inc = sat_inc(rdata);

  assign clearing = (state == ST_CLEAR);
  assign op_pop   = (state == ST_IDLE) && !op_empty;
  assign res_push = (state == ST_WRITE) && !res_full;

  always_comb begin
    true_next = cnt_true;
    ll_next   = cnt_ll;
    hh_next   = cnt_hh;
    mx_next   = cnt_mx;
    if (ev) begin
      true_next = sat_inc(cnt_true);
      unique case (op.cls)
        CLS_LOW_LOW:   ll_next = sat_inc(cnt_ll);
        CLS_HIGH_HIGH: hh_next = sat_inc(cnt_hh);
        default:       mx_next = sat_inc(cnt_mx);
      endcase
    end
  end

  always_comb begin
    if (op.is_read) begin
      res.voxel_count = hit ? OUT_W'(rdata) : '0;
    end else begin
      res.voxel_count = upd ? OUT_W'(vox_inc) : '0;
    end
    res.in_grid         = upd;
    res.true_total      = OUT_W'(true_next);
    res.count_low_low   = OUT_W'(ll_next);
    res.count_high_high = OUT_W'(hh_next);
    res.count_mixed     = OUT_W'(mx_next);
  end

  assign mem_we    = clearing || (res_push && upd);
  assign mem_waddr = clearing ? clr_addr : idx;
  assign mem_wdata = clearing ? '0 : vox_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      cnt_true <= '0;
      cnt_ll   <= '0;
      cnt_hh   <= '0;
      cnt_mx   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(DEPTH-1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (!op_empty) begin
            op    <= op_in;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!res_full) begin
            cnt_true <= true_next;
            cnt_ll   <= ll_next;
            cnt_hh   <= hh_next;
            cnt_mx   <= mx_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/voxel_decay_histogram_core.sv
// Voxel histogram core: an accepted word passes the two front stages, the op queue,
// the store read and the update into the result queue before its result reaches the
// result ports. The back end takes a new word only after the read/update/write of
// the last one in the count store. Synchronous reset restores the grid registers and
// zeroes all counters; the count store is then swept to zero, full held high
// meanwhile, config still written.
module voxel_decay_histogram_core #(
  parameter int DIM_X        = 64,
  parameter int DIM_Y        = 64,
  parameter int DIM_Z        = 32,
  parameter int COUNT_BITS   = 32,
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vdh_pkg::PADDR_W-1:0]      paddr,
  input  logic [vdh_pkg::PDATA_W-1:0]      pwdata,
  output logic [vdh_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  // input words
  input  logic                             push,
  output logic                             full,
  input  logic                             kind,
  input  logic signed [vdh_pkg::ID_W-1:0]  coinc_id,
  input  logic [vdh_pkg::CRYSTAL_W-1:0]    crystal_a,
  input  logic [vdh_pkg::CRYSTAL_W-1:0]    crystal_b,
  input  logic signed [vdh_pkg::POS_W-1:0] pos_x,
  input  logic signed [vdh_pkg::POS_W-1:0] pos_y,
  input  logic signed [vdh_pkg::POS_W-1:0] pos_z,
  input  logic [vdh_pkg::RADDR_W-1:0]      read_address,
  // result words
  output logic                             empty,
  input  logic                             pop,
  output logic [vdh_pkg::OUT_W-1:0]        voxel_count,
  output logic                             in_grid,
  output logic [vdh_pkg::OUT_W-1:0]        true_total,
  output logic [vdh_pkg::OUT_W-1:0]        count_low_low,
  output logic [vdh_pkg::OUT_W-1:0]        count_high_high,
  output logic [vdh_pkg::OUT_W-1:0]        count_mixed
);

  import vdh_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_we;

  // front -> op queue
  logic op_valid;
  op_t  op_front;
  logic opq_full;
  logic opq_empty;
  op_t  opq_head;
  logic opq_pop;

  // back -> result queue
  res_t res_back;
  logic res_push;
  logic resq_full;
  res_t res_head;
  logic clearing;

  // ---------------------------------------------------------------- config
  // Registers sit at byte offsets 0, 4, 8, 12; every write has no wait state.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_x      <= GRID_X_RST;
      cfg.grid_y      <= GRID_Y_RST;
      cfg.grid_z      <= GRID_Z_RST;
      cfg.split_index <= SPLIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_GRID_X:      cfg.grid_x      <= pwdata[GXY_W-1:0];
        REG_GRID_Y:      cfg.grid_y      <= pwdata[GXY_W-1:0];
        REG_GRID_Z:      cfg.grid_z      <= pwdata[GZ_W-1:0];
        REG_SPLIT_INDEX: cfg.split_index <= pwdata[SPLIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_X:      prdata = PDATA_W'(cfg.grid_x);
      REG_GRID_Y:      prdata = PDATA_W'(cfg.grid_y);
      REG_GRID_Z:      prdata = PDATA_W'(cfg.grid_z);
      REG_SPLIT_INDEX: prdata = PDATA_W'(cfg.split_index);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front end
  // Classification (ignored / class / axes in grid) and the linear address
  // x + y*gx + z*gx*gy; the clear pass holds it off via hold.
  vdh_front #(
    .DIM_X (DIM_X),
    .DIM_Y (DIM_Y),
    .DIM_Z (DIM_Z)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .hold         (clearing),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .coinc_id     (coinc_id),
    .crystal_a    (crystal_a),
    .crystal_b    (crystal_b),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .read_address (read_address),
    .op_valid     (op_valid),
    .op           (op_front),
    .op_ready     (!opq_full)
  );

  // decouples the address pipeline from the store sequencer
  vdh_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid),
    .din   (op_front),
    .full  (opq_full),
    .pop   (opq_pop),
    .dout  (opq_head),
    .empty (opq_empty)
  );

  // ---------------------------------------------------------------- back end
  vdh_back #(
    .DIM_X      (DIM_X),
    .DIM_Y      (DIM_Y),
    .DIM_Z      (DIM_Z),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_in    (opq_head),
    .op_empty (opq_empty),
    .op_pop   (opq_pop),
    .res      (res_back),
    .res_push (res_push),
    .res_full (resq_full),
    .clearing (clearing)
  );

  // result queue: lets the back end finish a word while the consumer stalls
  vdh_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_back),
    .full  (resq_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign voxel_count     = res_head.voxel_count;
  assign in_grid         = res_head.in_grid;
  assign true_total      = res_head.true_total;
  assign count_low_low   = res_head.count_low_low;
  assign count_high_high = res_head.count_high_high;
  assign count_mixed     = res_head.count_mixed;

  // ---------------------------------------------------------------- checks
  // reset always starts a clear pass: nothing accepted, nothing offered
  a_reset_clears : assert property (@(posedge clk) rst |=> (full && empty))
    else $error("clear pass not started after reset");

  // no result can exist while the store is being swept
  a_clear_quiet : assert property (@(posedge clk) disable iff (rst) clearing |-> empty)
    else $error("result offered during clear pass");

  // an in-grid event has just incremented its voxel
  a_in_grid_count : assert property (@(posedge clk) disable iff (rst)
    (!empty && in_grid) |-> (COUNT_BITS > 32 || voxel_count != '0))
    else $error("in-grid result with zero voxel count");

endmodule
